FILE: hdl/jsu_pkg.sv
package jsu_pkg;

    localparam int MAX_STRING_BYTES_DEFAULT = 65535;
    localparam int RESULT_SLOTS = 4;

    localparam logic [1:0] KIND_BYTE  = 2'd0;
    localparam logic [1:0] KIND_DONE  = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    localparam logic [3:0] ERR_NO_QUOTE     = 4'd0;
    localparam logic [3:0] ERR_CUT_ESCAPE   = 4'd1;
    localparam logic [3:0] ERR_SHORT_U      = 4'd2;
    localparam logic [3:0] ERR_BAD_HEX      = 4'd3;
    localparam logic [3:0] ERR_BAD_LOW_HEX  = 4'd4;
    localparam logic [3:0] ERR_LONE_HIGH    = 4'd5;
    localparam logic [3:0] ERR_LONE_LOW     = 4'd6;
    localparam logic [3:0] ERR_BAD_ESCAPE   = 4'd7;
    localparam logic [3:0] ERR_CONTROL      = 4'd8;
    localparam logic [3:0] ERR_BAD_UTF8     = 4'd9;
    localparam logic [3:0] ERR_UNTERMINATED = 4'd10;

    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH     = 8'h2F;
    localparam logic [7:0] CH_U         = 8'h75;

    localparam logic [15:0] HIGH_SUR_FIRST = 16'hD800;
    localparam logic [15:0] HIGH_SUR_LAST  = 16'hDBFF;
    localparam logic [15:0] LOW_SUR_FIRST  = 16'hDC00;
    localparam logic [15:0] LOW_SUR_LAST   = 16'hDFFF;
    localparam logic [20:0] SUPP_BASE      = 21'h10000;

    typedef enum logic [3:0] {
        PH_IDLE          = 4'd0,
        PH_BODY          = 4'd1,
        PH_ESC           = 4'd2,
        PH_UHEX          = 4'd3,
        PH_AFTER_HIGH    = 4'd4,
        PH_AFTER_HIGH_BS = 4'd5,
        PH_LOWHEX        = 4'd6,
        PH_UTF8_SECOND   = 4'd7,
        PH_UTF8_REST     = 4'd8
    } phase_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  out_byte;
        logic [3:0]  error_code;
        logic [15:0] error_offset;
        logic [15:0] decoded_length;
        logic        last;
    } result_t;

    typedef struct packed {
        logic [2:0]                    count;
        result_t [RESULT_SLOTS-1:0]    word;
    } batch_t;

    typedef struct packed {
        logic [2:0]      len;
        logic [3:0][7:0] bytes;
    } utf8_t;

    typedef struct packed {
        logic       ok;
        logic [3:0] value;
    } hex_t;

    typedef struct packed {
        logic       ok;
        logic [7:0] value;
    } esc_t;

    function automatic utf8_t utf8_encode(input logic [20:0] cp);
        utf8_t r;
        r.bytes = '0;
        if (cp < 21'h80) begin
            r.len = 3'd1;
            r.bytes[0] = {1'b0, cp[6:0]};
        end else if (cp < 21'h800) begin
            r.len = 3'd2;
            r.bytes[0] = {3'b110, cp[10:6]};
            r.bytes[1] = {2'b10, cp[5:0]};
        end else if (cp < 21'h10000) begin
            r.len = 3'd3;
            r.bytes[0] = {4'b1110, cp[15:12]};
            r.bytes[1] = {2'b10, cp[11:6]};
            r.bytes[2] = {2'b10, cp[5:0]};
        end else begin
            r.len = 3'd4;
            r.bytes[0] = {5'b11110, cp[20:18]};
            r.bytes[1] = {2'b10, cp[17:12]};
            r.bytes[2] = {2'b10, cp[11:6]};
            r.bytes[3] = {2'b10, cp[5:0]};
        end
        return r;
    endfunction

    function automatic hex_t hex_digit(input logic [7:0] b);
        hex_t r;
        r.ok = 1'b1;
        r.value = 4'd0;
        if (b >= 8'h30 && b <= 8'h39) begin
            r.value = 4'(b - 8'h30);
        end else if (b >= 8'h61 && b <= 8'h66) begin
            r.value = 4'(b - 8'h57);
        end else if (b >= 8'h41 && b <= 8'h46) begin
            r.value = 4'(b - 8'h37);
        end else begin
            r.ok = 1'b0;
        end
        return r;
    endfunction

    function automatic esc_t escape_map(input logic [7:0] b);
        esc_t r;
        r.ok = 1'b1;
        unique case (b)
            CH_QUOTE:     r.value = CH_QUOTE;
            CH_BACKSLASH: r.value = CH_BACKSLASH;
            CH_SLASH:     r.value = CH_SLASH;
            8'h62:        r.value = 8'h08;
            8'h66:        r.value = 8'h0C;
            8'h6E:        r.value = 8'h0A;
            8'h72:        r.value = 8'h0D;
            8'h74:        r.value = 8'h09;
            default:
            begin
                r.ok = 1'b0;
                r.value = 8'h00;
            end
        endcase
        return r;
    endfunction

    function automatic logic [15:0] sat_inc(input logic [15:0] v, input logic [15:0] lim);
        return (v >= lim) ? lim : v + 16'd1;
    endfunction

endpackage

FILE: hdl/jsu_decode.sv
module jsu_decode #(
    parameter int MAX_STRING_BYTES = jsu_pkg::MAX_STRING_BYTES_DEFAULT
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            accept,
    input  logic [7:0]      data_byte,
    input  logic            end_of_input,
    output jsu_pkg::batch_t batch
);

    localparam logic [15:0] SatLimit =
        (MAX_STRING_BYTES < 65535) ? 16'(MAX_STRING_BYTES) : 16'hFFFF;

    jsu_pkg::phase_t phase_reg, phase_next;
    logic [15:0] pos_reg, pos_next;
    logic [15:0] acc_reg, acc_next;
    logic [9:0]  high_reg, high_next;
    logic [2:0]  cnt_reg, cnt_next;
    logic        pend_reg, pend_next;
    logic [20:0] pcp_reg, pcp_next;
    logic [1:0]  cl_reg, cl_next;
    logic [15:0] seq_reg, seq_next;
    logic [15:0] outc_reg, outc_next;

    logic            fail_flag;
    logic [3:0]      fail_code;
    logic [15:0]     fail_off;
    logic            done_flag;
    logic            emit_flag;
    logic [20:0]     emit_cp;
    logic [15:0]     pos_inc;
    jsu_pkg::hex_t   hd;
    jsu_pkg::esc_t   esc;
    jsu_pkg::utf8_t  enc;
    logic [15:0]     acc_take;
    logic [2:0]      cnt_take;
    logic            pend_take;
    logic [20:0]     pcp_cat;
    logic [1:0]      cl_dec;
    logic [7:0]      lo_bound;
    logic [7:0]      hi_bound;
    logic [16:0]     outc_sum;
    logic            clear;

    always_comb
    begin
        pos_inc   = jsu_pkg::sat_inc(pos_reg, SatLimit);
        hd        = jsu_pkg::hex_digit(data_byte);
        esc       = jsu_pkg::escape_map(data_byte);
        acc_take  = hd.ok ? {acc_reg[11:0], hd.value} : acc_reg;
        pend_take = pend_reg | ~hd.ok;
        cnt_take  = cnt_reg + 3'd1;
        pcp_cat   = {pcp_reg[14:0], data_byte[5:0]};
        cl_dec    = cl_reg - 2'd1;
        lo_bound  = 8'h80;
        hi_bound  = 8'hBF;
        if (cl_reg == 2'd2 && pcp_reg == 21'd0)   lo_bound = 8'hA0;
        if (cl_reg == 2'd2 && pcp_reg == 21'hD)   hi_bound = 8'h9F;
        if (cl_reg == 2'd3 && pcp_reg == 21'd0)   lo_bound = 8'h90;
        if (cl_reg == 2'd3 && pcp_reg == 21'd4)   hi_bound = 8'h8F;

        phase_next = phase_reg;
        pos_next   = pos_reg;
        acc_next   = acc_reg;
        high_next  = high_reg;
        cnt_next   = cnt_reg;
        pend_next  = pend_reg;
        pcp_next   = pcp_reg;
        cl_next    = cl_reg;
        seq_next   = seq_reg;
        outc_next  = outc_reg;
        fail_flag  = 1'b0;
        fail_code  = jsu_pkg::ERR_NO_QUOTE;
        fail_off   = 16'd0;
        done_flag  = 1'b0;
        emit_flag  = 1'b0;
        emit_cp    = 21'd0;
        clear      = 1'b0;

        unique case (phase_reg) inside
            jsu_pkg::PH_IDLE:
            begin
                if (!end_of_input && data_byte == jsu_pkg::CH_QUOTE) begin
                    clear = 1'b1;
                end else begin
                    fail_flag = 1'b1;
                    fail_code = jsu_pkg::ERR_NO_QUOTE;
                end
            end
            jsu_pkg::PH_BODY:
            begin
                if (end_of_input) begin
                    fail_flag = 1'b1;
                    fail_code = jsu_pkg::ERR_UNTERMINATED;
                    fail_off  = pos_reg;
                end else if (data_byte == jsu_pkg::CH_QUOTE) begin
                    done_flag = 1'b1;
                end else if (data_byte == jsu_pkg::CH_BACKSLASH) begin
                    pos_next   = pos_inc;
                    phase_next = jsu_pkg::PH_ESC;
                end else if (data_byte < 8'h20) begin
                    fail_flag = 1'b1;
                    fail_code = jsu_pkg::ERR_CONTROL;
                    fail_off  = pos_reg;
                end else if (data_byte < 8'h80) begin
                    emit_flag = 1'b1;
                    emit_cp   = {13'd0, data_byte};
                    pos_next  = pos_inc;
                end else if (data_byte >= 8'hC2 && data_byte <= 8'hF4) begin
                    if (data_byte <= 8'hDF) begin
                        cl_next  = 2'd1;
                        pcp_next = {16'd0, data_byte[4:0]};
                    end else if (data_byte <= 8'hEF) begin
                        cl_next  = 2'd2;
                        pcp_next = {17'd0, data_byte[3:0]};
                    end else begin
                        cl_next  = 2'd3;
                        pcp_next = {18'd0, data_byte[2:0]};
                    end
                    seq_next   = pos_reg;
                    pos_next   = pos_inc;
                    phase_next = jsu_pkg::PH_UTF8_SECOND;
                end else begin
                    fail_flag = 1'b1;
                    fail_code = jsu_pkg::ERR_BAD_UTF8;
                    fail_off  = pos_reg;
                end
            end
            jsu_pkg::PH_ESC:
            begin
                if (end_of_input) begin
                    fail_flag = 1'b1;
                    fail_code = jsu_pkg::ERR_CUT_ESCAPE;
                    fail_off  = pos_reg;
                end else if (data_byte == jsu_pkg::CH_U) begin
                    pos_next   = pos_inc;
                    seq_next   = pos_inc;
                    acc_next   = 16'd0;
                    cnt_next   = 3'd0;
                    pend_next  = 1'b0;
                    phase_next = jsu_pkg::PH_UHEX;
                end else if (esc.ok) begin
                    emit_flag  = 1'b1;
                    emit_cp    = {13'd0, esc.value};
                    pos_next   = pos_inc;
                    phase_next = jsu_pkg::PH_BODY;
                end else begin
                    fail_flag = 1'b1;
                    fail_code = jsu_pkg::ERR_BAD_ESCAPE;
                    fail_off  = pos_reg;
                end
            end
            jsu_pkg::PH_UHEX:
            begin
                if (end_of_input) begin
                    fail_flag = 1'b1;
                    fail_code = jsu_pkg::ERR_SHORT_U;
                    fail_off  = seq_reg;
                end else begin
                    acc_next  = acc_take;
                    cnt_next  = cnt_take;
                    pend_next = pend_take;
                    pos_next  = pos_inc;
                    if (cnt_take >= 3'd4) begin
                        if (pend_take) begin
                            fail_flag = 1'b1;
                            fail_code = jsu_pkg::ERR_BAD_HEX;
                            fail_off  = seq_reg;
                        end else if (acc_take >= jsu_pkg::HIGH_SUR_FIRST
                                     && acc_take <= jsu_pkg::HIGH_SUR_LAST) begin
                            high_next  = acc_take[9:0];
                            seq_next   = pos_inc;
                            phase_next = jsu_pkg::PH_AFTER_HIGH;
                        end else if (acc_take >= jsu_pkg::LOW_SUR_FIRST
                                     && acc_take <= jsu_pkg::LOW_SUR_LAST) begin
                            fail_flag = 1'b1;
                            fail_code = jsu_pkg::ERR_LONE_LOW;
                            fail_off  = pos_inc;
                        end else begin
                            emit_flag  = 1'b1;
                            emit_cp    = {5'd0, acc_take};
                            phase_next = jsu_pkg::PH_BODY;
                        end
                    end
                end
            end
            jsu_pkg::PH_AFTER_HIGH:
            begin
                if (end_of_input || data_byte != jsu_pkg::CH_BACKSLASH) begin
                    fail_flag = 1'b1;
                    fail_code = jsu_pkg::ERR_LONE_HIGH;
                    fail_off  = seq_reg;
                end else begin
                    pos_next   = pos_inc;
                    phase_next = jsu_pkg::PH_AFTER_HIGH_BS;
                end
            end
            jsu_pkg::PH_AFTER_HIGH_BS:
            begin
                if (end_of_input || data_byte != jsu_pkg::CH_U) begin
                    fail_flag = 1'b1;
                    fail_code = jsu_pkg::ERR_LONE_HIGH;
                    fail_off  = seq_reg;
                end else begin
                    pos_next   = pos_inc;
                    acc_next   = 16'd0;
                    cnt_next   = 3'd0;
                    pend_next  = 1'b0;
                    phase_next = jsu_pkg::PH_LOWHEX;
                end
            end
            jsu_pkg::PH_LOWHEX:
            begin
                if (end_of_input) begin
                    fail_flag = 1'b1;
                    fail_code = jsu_pkg::ERR_LONE_HIGH;
                    fail_off  = seq_reg;
                end else begin
                    acc_next  = acc_take;
                    cnt_next  = cnt_take;
                    pend_next = pend_take;
                    pos_next  = pos_inc;
                    if (cnt_take >= 3'd4) begin
                        if (pend_take) begin
                            fail_flag = 1'b1;
                            fail_code = jsu_pkg::ERR_BAD_LOW_HEX;
                            fail_off  = seq_reg;
                        end else if (acc_take >= jsu_pkg::LOW_SUR_FIRST
                                     && acc_take <= jsu_pkg::LOW_SUR_LAST) begin
                            emit_flag  = 1'b1;
                            emit_cp    = jsu_pkg::SUPP_BASE
                                         + {1'b0, high_reg, acc_take[9:0]};
                            phase_next = jsu_pkg::PH_BODY;
                        end else begin
                            fail_flag = 1'b1;
                            fail_code = jsu_pkg::ERR_LONE_HIGH;
                            fail_off  = seq_reg;
                        end
                    end
                end
            end
            jsu_pkg::PH_UTF8_SECOND, jsu_pkg::PH_UTF8_REST:
            begin
                if (end_of_input
                    || (phase_reg == jsu_pkg::PH_UTF8_SECOND
                        && (data_byte < lo_bound || data_byte > hi_bound))
                    || (phase_reg == jsu_pkg::PH_UTF8_REST
                        && data_byte[7:6] != 2'b10)) begin
                    fail_flag = 1'b1;
                    fail_code = jsu_pkg::ERR_BAD_UTF8;
                    fail_off  = seq_reg;
                end else begin
                    pcp_next = pcp_cat;
                    cl_next  = cl_dec;
                    pos_next = pos_inc;
                    if (cl_dec == 2'd0) begin
                        emit_flag  = 1'b1;
                        emit_cp    = pcp_cat;
                        phase_next = jsu_pkg::PH_BODY;
                    end else begin
                        phase_next = jsu_pkg::PH_UTF8_REST;
                    end
                end
            end
            default:
            begin
                clear = 1'b1;
            end
        endcase

        enc      = jsu_pkg::utf8_encode(emit_cp);
        outc_sum = {1'b0, outc_reg} + {14'd0, enc.len};
        if (emit_flag) begin
            outc_next = (outc_sum >= {1'b0, SatLimit}) ? SatLimit : outc_sum[15:0];
        end

        batch = '0;
        if (fail_flag) begin
            batch.count                = 3'd1;
            batch.word[0].kind         = jsu_pkg::KIND_ERROR;
            batch.word[0].error_code   = fail_code;
            batch.word[0].error_offset = fail_off;
            batch.word[0].last         = 1'b1;
        end else if (done_flag) begin
            batch.count                  = 3'd1;
            batch.word[0].kind           = jsu_pkg::KIND_DONE;
            batch.word[0].decoded_length = outc_reg;
            batch.word[0].last           = 1'b1;
        end else if (emit_flag) begin
            batch.count = enc.len;
            for (int i = 0; i < jsu_pkg::RESULT_SLOTS; i++) begin
                batch.word[i].kind     = jsu_pkg::KIND_BYTE;
                batch.word[i].out_byte = enc.bytes[i];
                batch.word[i].last     = (3'(i) == enc.len - 3'd1);
            end
        end

        if (fail_flag || done_flag || clear) begin
            phase_next = jsu_pkg::PH_IDLE;
            pos_next   = 16'd0;
            acc_next   = 16'd0;
            high_next  = 10'd0;
            cnt_next   = 3'd0;
            pend_next  = 1'b0;
            pcp_next   = 21'd0;
            cl_next    = 2'd0;
            seq_next   = 16'd0;
            outc_next  = 16'd0;
        end
        if (clear && phase_reg == jsu_pkg::PH_IDLE) begin
            pos_next   = 16'd1;
            phase_next = jsu_pkg::PH_BODY;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg <= jsu_pkg::PH_IDLE;
            pos_reg   <= 16'd0;
            acc_reg   <= 16'd0;
            high_reg  <= 10'd0;
            cnt_reg   <= 3'd0;
            pend_reg  <= 1'b0;
            pcp_reg   <= 21'd0;
            cl_reg    <= 2'd0;
            seq_reg   <= 16'd0;
            outc_reg  <= 16'd0;
        end else if (accept) begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            acc_reg   <= acc_next;
            high_reg  <= high_next;
            cnt_reg   <= cnt_next;
            pend_reg  <= pend_next;
            pcp_reg   <= pcp_next;
            cl_reg    <= cl_next;
            seq_reg   <= seq_next;
            outc_reg  <= outc_next;
        end
    end

endmodule

FILE: hdl/jsu_result_buf.sv
module jsu_result_buf (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  jsu_pkg::batch_t  batch,
    output logic             load_ready,
    output logic             out_valid,
    input  logic             out_ready,
    output jsu_pkg::result_t out_word
);

    jsu_pkg::result_t [jsu_pkg::RESULT_SLOTS-1:0] word_reg;
    logic [2:0] cnt_reg, cnt_next;
    logic [1:0] rd_reg, rd_next;
    logic       take;

    always_comb
    begin
        out_valid  = (cnt_reg != 3'd0);
        out_word   = word_reg[rd_reg];
        take       = out_valid && out_ready;
        load_ready = (cnt_reg == 3'd0) || (cnt_reg == 3'd1 && out_ready);
        cnt_next   = cnt_reg;
        rd_next    = rd_reg;
        if (take) begin
            cnt_next = cnt_reg - 3'd1;
            rd_next  = rd_reg + 2'd1;
        end
        if (load) begin
            cnt_next = batch.count;
            rd_next  = 2'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cnt_reg <= 3'd0;
            rd_reg  <= 2'd0;
        end else begin
            cnt_reg <= cnt_next;
            rd_reg  <= rd_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load) begin
            word_reg <= batch.word;
        end
    end

endmodule

FILE: hdl/json_string_unescape_to_utf8_core.sv
// JSON string literal decoder with UTF-8 output.
// Input channel (in_valid/in_ready): one word per text byte, starting at
// the opening quote; end_of_input marks the end of the text with no byte.
// Output channel (out_valid/out_ready): kind 0 words carry decoded UTF-8
// bytes, a kind 1 word closes the string with its decoded length, a kind 2
// word reports an error code and offset; bytes sent before an error are
// void. last marks the final word caused by one input word.
// Results of an input word are registered and appear in the cycle after it
// is taken. One input word per cycle while each word gives at most one result
// and out_ready is high; after a word that gives n results (up to four bytes of
// one code point), the next input word is taken with the buffer's last word.
// The decode state advances only when an input word is taken, so a stalled
// receiver holds the input channel once the buffer holds any word.
// Reset clears the decode state and the result buffer; the block then waits
// for an opening quote. Offsets and lengths saturate at MAX_STRING_BYTES
// or 65535, whichever is smaller.
module json_string_unescape_to_utf8_core #(
    parameter int MAX_STRING_BYTES = jsu_pkg::MAX_STRING_BYTES_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        end_of_input,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  kind,
    output logic [7:0]  out_byte,
    output logic [3:0]  error_code,
    output logic [15:0] error_offset,
    output logic [15:0] decoded_length,
    output logic        last
);

    jsu_pkg::batch_t  batch;
    jsu_pkg::result_t word;
    logic             accept;

    assign accept = in_valid && in_ready;

    jsu_decode #(
        .MAX_STRING_BYTES(MAX_STRING_BYTES)
    ) u_decode (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .data_byte   (data_byte),
        .end_of_input(end_of_input),
        .batch       (batch)
    );

    jsu_result_buf u_result_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (accept),
        .batch     (batch),
        .load_ready(in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_word  (word)
    );

    assign kind           = word.kind;
    assign out_byte       = word.out_byte;
    assign error_code     = word.error_code;
    assign error_offset   = word.error_offset;
    assign decoded_length = word.decoded_length;
    assign last           = word.last;

endmodule

FILE: verif/tb_json_string_unescape_to_utf8_core.sv
module tb_json_string_unescape_to_utf8_core;

    localparam logic [15:0] SAT_MAX      = 16'hFFFF;
    localparam int          HOLD_CYCLES  = 300;
    localparam int          RANDOM_WORDS = 400;

    localparam logic [7:0] CH_SPACE      = 8'h20;
    localparam logic [7:0] CH_ZERO       = 8'h30;
    localparam logic [7:0] CH_NINE       = 8'h39;
    localparam logic [7:0] CH_UPPER_A    = 8'h41;
    localparam logic [7:0] CH_UPPER_F    = 8'h46;
    localparam logic [7:0] CH_LOWER_A    = 8'h61;
    localparam logic [7:0] CH_LOWER_F    = 8'h66;
    localparam logic [7:0] CH_LOWER_G    = 8'h67;
    localparam logic [7:0] ESC_B         = 8'h62;
    localparam logic [7:0] ESC_F         = 8'h66;
    localparam logic [7:0] ESC_N         = 8'h6E;
    localparam logic [7:0] ESC_R         = 8'h72;
    localparam logic [7:0] ESC_T         = 8'h74;
    localparam logic [7:0] CTL_BACKSPACE = 8'h08;
    localparam logic [7:0] CTL_FORMFEED  = 8'h0C;
    localparam logic [7:0] CTL_NEWLINE   = 8'h0A;
    localparam logic [7:0] CTL_RETURN    = 8'h0D;
    localparam logic [7:0] CTL_TAB       = 8'h09;

    localparam logic [7:0][7:0] SIMPLE_ESC = {jsu_pkg::CH_QUOTE, jsu_pkg::CH_BACKSLASH,
                                              jsu_pkg::CH_SLASH, ESC_B,
                                              ESC_F, ESC_N, ESC_R, ESC_T};
    localparam logic [7:0][20:0] EDGE_CPS = {21'h80, 21'h7FF, 21'h800, 21'hD7FF,
                                             21'hE000, 21'hFFFF, 21'h10000, 21'h10FFFF};

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  data_byte;
    logic        end_of_input;
    logic        out_valid;
    logic        out_ready;
    logic [1:0]  kind;
    logic [7:0]  out_byte;
    logic [3:0]  error_code;
    logic [15:0] error_offset;
    logic [15:0] decoded_length;
    logic        last;

    json_string_unescape_to_utf8_core DUT (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .data_byte(data_byte),
        .end_of_input(end_of_input),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .kind(kind),
        .out_byte(out_byte),
        .error_code(error_code),
        .error_offset(error_offset),
        .decoded_length(decoded_length),
        .last(last)
    );

    class utf8_unescape_sb;
        jsu_pkg::result_t expected_words[$];
        jsu_pkg::result_t step_words[$];
        jsu_pkg::phase_t  stage;
        logic [15:0] pos;
        logic [15:0] hex_acc;
        logic [15:0] high_half;
        logic [15:0] seq_start;
        logic [15:0] out_count;
        logic [2:0]  digits;
        logic        hex_bad;
        logic [20:0] cp_acc;
        logic [1:0]  cont_left;
        int          failures;

        function new();
            clear();
            failures = 0;
        endfunction

        static function logic hex_value(input logic [7:0] b, output logic [3:0] v);
            v = '0;
            if (b >= CH_ZERO && b <= CH_NINE) begin
                v = 4'(b - CH_ZERO);
                return 1'b1;
            end
            if (b >= CH_LOWER_A && b <= CH_LOWER_F) begin
                v = 4'(b - CH_LOWER_A + 8'd10);
                return 1'b1;
            end
            if (b >= CH_UPPER_A && b <= CH_UPPER_F) begin
                v = 4'(b - CH_UPPER_A + 8'd10);
                return 1'b1;
            end
            return 1'b0;
        endfunction

        static function int encode_cp(input logic [20:0] cp, output logic [3:0][7:0] seq);
            logic [20:0] v;
            int          n;
            int          i;
            v = cp;
            seq = '0;
            n = (cp < 21'h80) ? 1 : (cp < 21'h800) ? 2 : (cp < 21'h10000) ? 3 : 4;
            for (i = n - 1; i > 0; i--)
            begin
                seq[i] = {2'b10, v[5:0]};
                v = v >> 6;
            end
            case (n)
                1: seq[0] = v[7:0];
                2: seq[0] = 8'hC0 | v[7:0];
                3: seq[0] = 8'hE0 | v[7:0];
                default: seq[0] = 8'hF0 | v[7:0];
            endcase
            return n;
        endfunction

        function logic [15:0] bump(input logic [15:0] v);
            return (v >= SAT_MAX) ? SAT_MAX : v + 16'd1;
        endfunction

        function void clear();
            stage = jsu_pkg::PH_IDLE;
            pos = '0;
            hex_acc = '0;
            high_half = '0;
            seq_start = '0;
            out_count = '0;
            digits = '0;
            hex_bad = 1'b0;
            cp_acc = '0;
            cont_left = '0;
        endfunction

        function void queue_result(input logic [1:0] k, input logic [7:0] b,
                                   input logic [3:0] c, input logic [15:0] off,
                                   input logic [15:0] len);
            jsu_pkg::result_t r;
            r.kind = k;
            r.out_byte = b;
            r.error_code = c;
            r.error_offset = off;
            r.decoded_length = len;
            r.last = 1'b0;
            step_words.push_back(r);
        endfunction

        function void fail(input logic [3:0] c, input logic [15:0] off);
            queue_result(jsu_pkg::KIND_ERROR, '0, c, off, '0);
            clear();
        endfunction

        function void emit_byte(input logic [7:0] b);
            queue_result(jsu_pkg::KIND_BYTE, b, '0, '0, '0);
            out_count = bump(out_count);
        endfunction

        function void emit_cp(input logic [20:0] cp);
            logic [3:0][7:0] seq;
            int              n;
            int              i;
            n = encode_cp(cp, seq);
            for (i = 0; i < n; i++)
                emit_byte(seq[i]);
        endfunction

        function void start_hex();
            hex_acc = '0;
            digits = '0;
            hex_bad = 1'b0;
        endfunction

        function void hex_step(input logic [7:0] b);
            logic [3:0] v;
            if (hex_value(b, v))
                hex_acc = {hex_acc[11:0], v};
            else
                hex_bad = 1'b1;
            digits = digits + 3'd1;
            pos = bump(pos);
        endfunction

        function void continuation(input logic [7:0] b);
            cp_acc = {cp_acc[14:0], b[5:0]};
            cont_left = cont_left - 2'd1;
            pos = bump(pos);
            if (cont_left == 2'd0) begin
                emit_cp(cp_acc);
                stage = jsu_pkg::PH_BODY;
            end else begin
                stage = jsu_pkg::PH_UTF8_REST;
            end
        endfunction

        function void body(input logic [7:0] b);
            if (b == jsu_pkg::CH_QUOTE) begin
                queue_result(jsu_pkg::KIND_DONE, '0, '0, '0, out_count);
                clear();
            end else if (b == jsu_pkg::CH_BACKSLASH) begin
                pos = bump(pos);
                stage = jsu_pkg::PH_ESC;
            end else if (b < CH_SPACE) begin
                fail(jsu_pkg::ERR_CONTROL, pos);
            end else if (b < 8'h80) begin
                emit_byte(b);
                pos = bump(pos);
            end else begin
                if (b >= 8'hC2 && b <= 8'hDF) begin
                    cont_left = 2'd1;
                    cp_acc = {16'd0, b[4:0]};
                end else if (b >= 8'hE0 && b <= 8'hEF) begin
                    cont_left = 2'd2;
                    cp_acc = {17'd0, b[3:0]};
                end else if (b >= 8'hF0 && b <= 8'hF4) begin
                    cont_left = 2'd3;
                    cp_acc = {18'd0, b[2:0]};
                end else begin
                    fail(jsu_pkg::ERR_BAD_UTF8, pos);
                    return;
                end
                seq_start = pos;
                pos = bump(pos);
                stage = jsu_pkg::PH_UTF8_SECOND;
            end
        endfunction

        function void escape(input logic [7:0] b);
            logic [7:0] v;
            case (b) inside
                jsu_pkg::CH_QUOTE, jsu_pkg::CH_BACKSLASH, jsu_pkg::CH_SLASH: v = b;
                ESC_B: v = CTL_BACKSPACE;
                ESC_F: v = CTL_FORMFEED;
                ESC_N: v = CTL_NEWLINE;
                ESC_R: v = CTL_RETURN;
                ESC_T: v = CTL_TAB;
                jsu_pkg::CH_U:
                begin
                    pos = bump(pos);
                    seq_start = pos;
                    start_hex();
                    stage = jsu_pkg::PH_UHEX;
                    return;
                end
                default:
                begin
                    fail(jsu_pkg::ERR_BAD_ESCAPE, pos);
                    return;
                end
            endcase
            emit_byte(v);
            pos = bump(pos);
            stage = jsu_pkg::PH_BODY;
        endfunction

        function void take_input_word(input logic [7:0] b, input logic eoi);
            logic [7:0]  lo;
            logic [7:0]  hi;
            logic [20:0] joined;
            step_words.delete();
            case (stage)
                jsu_pkg::PH_IDLE:
                begin
                    if (!eoi && b == jsu_pkg::CH_QUOTE) begin
                        clear();
                        pos = 16'd1;
                        stage = jsu_pkg::PH_BODY;
                    end else begin
                        fail(jsu_pkg::ERR_NO_QUOTE, '0);
                    end
                end
                jsu_pkg::PH_BODY:
                begin
                    if (eoi)
                        fail(jsu_pkg::ERR_UNTERMINATED, pos);
                    else
                        body(b);
                end
                jsu_pkg::PH_ESC:
                begin
                    if (eoi)
                        fail(jsu_pkg::ERR_CUT_ESCAPE, pos);
                    else
                        escape(b);
                end
                jsu_pkg::PH_UHEX:
                begin
                    if (eoi) begin
                        fail(jsu_pkg::ERR_SHORT_U, seq_start);
                    end else begin
                        hex_step(b);
                        if (digits == 3'd4) begin
                            if (hex_bad) begin
                                fail(jsu_pkg::ERR_BAD_HEX, seq_start);
                            end else if (hex_acc >= jsu_pkg::HIGH_SUR_FIRST
                                         && hex_acc <= jsu_pkg::HIGH_SUR_LAST) begin
                                high_half = hex_acc;
                                seq_start = pos;
                                stage = jsu_pkg::PH_AFTER_HIGH;
                            end else if (hex_acc >= jsu_pkg::LOW_SUR_FIRST
                                         && hex_acc <= jsu_pkg::LOW_SUR_LAST) begin
                                fail(jsu_pkg::ERR_LONE_LOW, pos);
                            end else begin
                                emit_cp({5'd0, hex_acc});
                                stage = jsu_pkg::PH_BODY;
                            end
                        end
                    end
                end
                jsu_pkg::PH_AFTER_HIGH:
                begin
                    if (eoi || b != jsu_pkg::CH_BACKSLASH) begin
                        fail(jsu_pkg::ERR_LONE_HIGH, seq_start);
                    end else begin
                        pos = bump(pos);
                        stage = jsu_pkg::PH_AFTER_HIGH_BS;
                    end
                end
                jsu_pkg::PH_AFTER_HIGH_BS:
                begin
                    if (eoi || b != jsu_pkg::CH_U) begin
                        fail(jsu_pkg::ERR_LONE_HIGH, seq_start);
                    end else begin
                        pos = bump(pos);
                        start_hex();
                        stage = jsu_pkg::PH_LOWHEX;
                    end
                end
                jsu_pkg::PH_LOWHEX:
                begin
                    if (eoi) begin
                        fail(jsu_pkg::ERR_LONE_HIGH, seq_start);
                    end else begin
                        hex_step(b);
                        if (digits == 3'd4) begin
                            if (hex_bad) begin
                                fail(jsu_pkg::ERR_BAD_LOW_HEX, seq_start);
                            end else if (hex_acc >= jsu_pkg::LOW_SUR_FIRST
                                         && hex_acc <= jsu_pkg::LOW_SUR_LAST) begin
                                joined = jsu_pkg::SUPP_BASE
                                         + {1'b0, high_half[9:0], hex_acc[9:0]};
                                emit_cp(joined);
                                stage = jsu_pkg::PH_BODY;
                            end else begin
                                fail(jsu_pkg::ERR_LONE_HIGH, seq_start);
                            end
                        end
                    end
                end
                jsu_pkg::PH_UTF8_SECOND:
                begin
                    if (eoi) begin
                        fail(jsu_pkg::ERR_BAD_UTF8, seq_start);
                    end else begin
                        lo = 8'h80;
                        hi = 8'hBF;
                        if (cont_left == 2'd2 && cp_acc == 21'h0) lo = 8'hA0;
                        if (cont_left == 2'd2 && cp_acc == 21'hD) hi = 8'h9F;
                        if (cont_left == 2'd3 && cp_acc == 21'h0) lo = 8'h90;
                        if (cont_left == 2'd3 && cp_acc == 21'h4) hi = 8'h8F;
                        if (b < lo || b > hi)
                            fail(jsu_pkg::ERR_BAD_UTF8, seq_start);
                        else
                            continuation(b);
                    end
                end
                jsu_pkg::PH_UTF8_REST:
                begin
                    if (eoi || b[7:6] != 2'b10)
                        fail(jsu_pkg::ERR_BAD_UTF8, seq_start);
                    else
                        continuation(b);
                end
                default: clear();
            endcase
            if (step_words.size() > 0)
                step_words[step_words.size() - 1].last = 1'b1;
            foreach (step_words[i])
                expected_words.push_back(step_words[i]);
        endfunction

        function void check_output_word(input logic [1:0] k, input logic [7:0] b,
                                        input logic [3:0] c, input logic [15:0] off,
                                        input logic [15:0] len, input logic l);
            jsu_pkg::result_t want;
            if (expected_words.size() == 0) begin
                failures++;
                if (failures <= 10)
                    $display("unexpected word: kind %0d byte %02h code %0d off %0d len %0d last %0d",
                             k, b, c, off, len, l);
                return;
            end
            want = expected_words.pop_front();
            if (k !== want.kind || b !== want.out_byte || c !== want.error_code ||
                off !== want.error_offset || len !== want.decoded_length || l !== want.last) begin
                failures++;
                if (failures <= 10)
                    $display("mismatch (exp/got): kind %0d/%0d byte %02h/%02h code %0d/%0d %s",
                             want.kind, k, want.out_byte, b, want.error_code, c,
                             $sformatf("offset %0d/%0d length %0d/%0d last %0d/%0d",
                                       want.error_offset, off, want.decoded_length, len,
                                       want.last, l));
            end
        endfunction

        function void report_leftover();
            if (expected_words.size() != 0) begin
                failures++;
                $display("%0d expected words never arrived", expected_words.size());
            end
        endfunction
    endclass

    utf8_unescape_sb sb;
    logic [8:0]      txt[$];
    int unsigned     burst_left;
    bit              holdoff_req;
    int              words_sent;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #6000000;
        $display("Verification failed");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_output_word(kind, out_byte, error_code, error_offset, decoded_length, last);
    end

    initial
    begin : receiver
        int unsigned mode;
        int unsigned span;
        logic [7:0]  mask;
        int unsigned k;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(16, 200);
            mask = 8'($urandom);
            for (k = 0; k < span; k++)
            begin
                @(negedge clk);
                if (holdoff_req) begin
                    holdoff_req = 1'b0;
                    out_ready <= 1'b0;
                    repeat (HOLD_CYCLES) @(negedge clk);
                end
                case (mode)
                    0: out_ready <= 1'b1;
                    1: out_ready <= 1'($urandom_range(0, 1));
                    2: out_ready <= ($urandom_range(0, 3) == 0);
                    default: out_ready <= mask[k % 8];
                endcase
            end
        end
    end

    function automatic void put_byte(input logic [7:0] b);
        txt.push_back({1'b0, b});
    endfunction

    function automatic void put_end();
        txt.push_back({1'b1, 8'($urandom)});
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        if (n < 4'd10)
            return CH_ZERO + 8'(n);
        return ($urandom_range(0, 1) ? CH_UPPER_A : CH_LOWER_A) + 8'(n) - 8'd10;
    endfunction

    function automatic logic [7:0] non_hex_byte();
        logic [7:0] b;
        logic [3:0] v;
        b = 8'($urandom);
        while (utf8_unescape_sb::hex_value(b, v))
            b = 8'($urandom);
        return b;
    endfunction

    function automatic void put_u(input logic [15:0] v, input int digits);
        int i;
        put_byte(jsu_pkg::CH_BACKSLASH);
        put_byte(jsu_pkg::CH_U);
        for (i = 3; i >= 4 - digits; i--)
            put_byte(hex_char(v[4*i +: 4]));
    endfunction

    function automatic void put_u_bad(input logic [15:0] v);
        int i;
        int k;
        k = $urandom_range(0, 3);
        put_byte(jsu_pkg::CH_BACKSLASH);
        put_byte(jsu_pkg::CH_U);
        for (i = 3; i >= 0; i--)
            put_byte(i == k ? non_hex_byte() : hex_char(v[4*i +: 4]));
    endfunction

    function automatic logic [15:0] high_sur();
        return 16'($urandom_range(jsu_pkg::HIGH_SUR_FIRST, jsu_pkg::HIGH_SUR_LAST));
    endfunction

    function automatic logic [15:0] low_sur();
        return 16'($urandom_range(jsu_pkg::LOW_SUR_FIRST, jsu_pkg::LOW_SUR_LAST));
    endfunction

    function automatic logic [20:0] pick_cp();
        logic [20:0] cp;
        case ($urandom_range(0, 9)) inside
            0: cp = EDGE_CPS[$urandom_range(0, 7)];
            1, 2, 3: cp = 21'($urandom_range(21'h80, 21'h7FF));
            4, 5, 6:
            begin
                cp = 21'($urandom_range(21'h800, 21'hFFFF));
                if (cp >= 21'hD800 && cp <= 21'hDFFF)
                    cp = cp ^ 21'h8000;
            end
            default: cp = 21'($urandom_range(21'h10000, 21'h10FFFF));
        endcase
        return cp;
    endfunction

    function automatic void put_cp_literal(input logic [20:0] cp);
        logic [3:0][7:0] seq;
        int              n;
        int              i;
        n = utf8_unescape_sb::encode_cp(cp, seq);
        for (i = 0; i < n; i++)
            put_byte(seq[i]);
    endfunction

    function automatic void put_ascii();
        logic [7:0] b;
        b = 8'($urandom_range(CH_SPACE, 8'h7F));
        if (b == jsu_pkg::CH_QUOTE || b == jsu_pkg::CH_BACKSLASH)
            b = CH_SPACE;
        put_byte(b);
    endfunction

    function automatic void put_good_piece();
        logic [15:0] v;
        case ($urandom_range(0, 5)) inside
            0, 1: put_ascii();
            2:
            begin
                put_byte(jsu_pkg::CH_BACKSLASH);
                put_byte(SIMPLE_ESC[$urandom_range(0, 7)]);
            end
            3:
            begin
                v = $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 16'h7FF));
                if (v >= jsu_pkg::HIGH_SUR_FIRST && v <= jsu_pkg::LOW_SUR_LAST)
                    v = v ^ 16'h8000;
                put_u(v, 4);
            end
            4:
            begin
                put_u(high_sur(), 4);
                put_u(low_sur(), 4);
            end
            default: put_cp_literal(pick_cp());
        endcase
    endfunction

    function automatic void put_bad_piece();
        logic [7:0] b;
        case ($urandom_range(0, 13))
            0: put_byte(8'($urandom));
            1: put_byte(8'($urandom_range(0, 31)));
            2:
            begin
                put_byte(jsu_pkg::CH_BACKSLASH);
                put_byte(8'($urandom));
            end
            3: put_u_bad(16'($urandom));
            4: put_u(low_sur(), 4);
            5:
            begin
                put_u(high_sur(), 4);
                put_byte(8'($urandom));
            end
            6:
            begin
                put_u(high_sur(), 4);
                put_byte(jsu_pkg::CH_BACKSLASH);
                put_byte(8'($urandom));
            end
            7:
            begin
                put_u(high_sur(), 4);
                put_u_bad(16'($urandom));
            end
            8:
            begin
                put_u(high_sur(), 4);
                put_u(16'($urandom_range(0, 16'hDBFF)), 4);
            end
            9: put_byte($urandom_range(0, 1) ? 8'($urandom_range(8'h80, 8'hC1))
                                              : 8'($urandom_range(8'hF5, 8'hFF)));
            10:
            begin
                case ($urandom_range(0, 4))
                    0:
                    begin
                        put_byte(8'hE0);
                        put_byte(8'($urandom_range(8'h80, 8'h9F)));
                    end
                    1:
                    begin
                        put_byte(8'hED);
                        put_byte(8'($urandom_range(8'hA0, 8'hBF)));
                    end
                    2:
                    begin
                        put_byte(8'hF0);
                        put_byte(8'($urandom_range(8'h80, 8'h8F)));
                    end
                    3:
                    begin
                        put_byte(8'hF4);
                        put_byte(8'($urandom_range(8'h90, 8'hBF)));
                    end
                    default:
                    begin
                        b = 8'($urandom);
                        if (b[7:6] == 2'b10)
                            b = b ^ 8'h40;
                        put_byte(8'hC2);
                        put_byte(b);
                    end
                endcase
            end
            11:
            begin
                b = 8'($urandom);
                if (b[7:6] == 2'b10)
                    b = b ^ 8'h40;
                put_byte($urandom_range(0, 1) ? 8'hE1 : 8'hF1);
                put_byte(8'h80);
                put_byte(b);
            end
            12:
            begin
                case ($urandom_range(0, 5))
                    0: put_byte(jsu_pkg::CH_BACKSLASH);
                    1: put_u(16'($urandom), $urandom_range(0, 3));
                    2: put_byte(8'hE1);
                    3: put_u(high_sur(), 4);
                    4:
                    begin
                        put_u(high_sur(), 4);
                        put_byte(jsu_pkg::CH_BACKSLASH);
                    end
                    default:
                    begin
                        put_u(high_sur(), 4);
                        put_u(16'($urandom), 2);
                    end
                endcase
                put_end();
            end
            default: put_end();
        endcase
    endfunction

    function automatic void build_random_string();
        int n;
        int r;
        if ($urandom_range(0, 9) == 0)
            put_byte(8'($urandom));
        else
            put_byte(jsu_pkg::CH_QUOTE);
        n = $urandom_range(0, 10);
        repeat (n)
        begin
            if ($urandom_range(0, 99) < 15)
                put_bad_piece();
            else
                put_good_piece();
        end
        r = $urandom_range(0, 19);
        if (r < 16)
            put_byte(jsu_pkg::CH_QUOTE);
        if (r >= 14 && r < 18)
            put_end();
    endfunction

    task automatic send_word(input logic [7:0] b, input logic eoi);
        int unsigned gap;
        gap = 0;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = $urandom_range(0, 6);
        end
        @(negedge clk);
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        data_byte <= b;
        end_of_input <= eoi;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.take_input_word(b, eoi);
        words_sent++;
        if (burst_left != 0)
            burst_left--;
    endtask

    task automatic send_text();
        foreach (txt[i])
            send_word(txt[i][7:0], txt[i][8]);
        txt.delete();
    endtask

    task automatic release_bus();
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    task automatic wait_drained(input int limit);
        int n;
        n = 0;
        while (sb.expected_words.size() != 0 && n < limit)
        begin
            @(posedge clk);
            n++;
        end
    endtask

    initial
    begin : stimulus
        int  random_start;
        bit  holdoff_done;
        sb = new();
        rst_n = 1'b0;
        in_valid = 1'b0;
        data_byte = '0;
        end_of_input = 1'b0;
        burst_left = 0;
        holdoff_req = 1'b0;
        holdoff_done = 1'b0;
        words_sent = 0;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;

        put_byte(8'h00);
        put_byte(jsu_pkg::CH_QUOTE);
        put_u(jsu_pkg::HIGH_SUR_FIRST, 4);
        put_u(jsu_pkg::LOW_SUR_FIRST, 4);
        put_byte(jsu_pkg::CH_QUOTE);
        put_byte(jsu_pkg::CH_QUOTE);
        put_byte(8'hFF);
        put_byte(jsu_pkg::CH_QUOTE);
        put_byte(jsu_pkg::CH_BACKSLASH);
        put_byte(jsu_pkg::CH_U);
        put_byte(hex_char(4'd1));
        put_byte(CH_LOWER_G);
        put_end();
        put_byte(jsu_pkg::CH_QUOTE);
        put_end();
        put_byte(jsu_pkg::CH_QUOTE);
        put_byte(jsu_pkg::CH_QUOTE);
        send_text();
        release_bus();
        wait_drained(1000000);

        random_start = words_sent;
        while (words_sent - random_start < RANDOM_WORDS)
        begin
            build_random_string();
            if (!holdoff_done && words_sent - random_start >= 150) begin
                holdoff_req = 1'b1;
                holdoff_done = 1'b1;
            end
            send_text();
        end
        release_bus();
        wait_drained(200000);

        repeat (8) @(posedge clk);
        sb.report_leftover();
        if (sb.failures == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
